// ===== sv/sha1md_pkg.sv =====
`timescale 1ns / 1ps
// sha1md_pkg: shared types and constants of the sha-1 digest unit
// depends on nothing; used by the round unit, schedule line and top level

package sha1md_pkg;

  typedef logic [31:0] word_t;

  // working variables a..e of the compression
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
  } rvars_t;

  // schedule line control
  typedef struct packed {
    logic shift;   // advance the line by one word
    logic ext;     // take the external word instead of the schedule word
    logic expand;  // round index 16 or above: produce an expanded word
  } sched_ctl_t;

  localparam word_t IV0 = 32'h67452301;
  localparam word_t IV1 = 32'hEFCDAB89;
  localparam word_t IV2 = 32'h98BADCFE;
  localparam word_t IV3 = 32'h10325476;
  localparam word_t IV4 = 32'hC3D2E1F0;

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam int unsigned ROUND_W = 7;
  localparam logic [ROUND_W-1:0] ROUND_LAST  = 7'd79;
  localparam logic [ROUND_W-1:0] ROUND_EXP   = 7'd16;
  localparam logic [ROUND_W-1:0] ROUND_STG1  = 7'd20;
  localparam logic [ROUND_W-1:0] ROUND_STG2  = 7'd40;
  localparam logic [ROUND_W-1:0] ROUND_STG3  = 7'd60;

endpackage

// ===== sv/sha1md_round.sv =====
`timescale 1ns / 1ps
// sha1md_round: one sha-1 round, shared by all 80 rounds of a block
// depends on sha1md_pkg

module sha1md_round (
  input  sha1md_pkg::rvars_t                    vars_i,
  input  sha1md_pkg::word_t                     w_i,
  input  logic [sha1md_pkg::ROUND_W-1:0]        idx_i,
  output sha1md_pkg::rvars_t                    vars_o
);

  sha1md_pkg::word_t f;
  sha1md_pkg::word_t k;
  sha1md_pkg::word_t t;

  always_comb begin
    if (idx_i < sha1md_pkg::ROUND_STG1) begin
      f = (vars_i.b & vars_i.c) | (~vars_i.b & vars_i.d);
      k = sha1md_pkg::K0;
    end else if (idx_i < sha1md_pkg::ROUND_STG2) begin
      f = vars_i.b ^ vars_i.c ^ vars_i.d;
      k = sha1md_pkg::K1;
    end else if (idx_i < sha1md_pkg::ROUND_STG3) begin
      f = (vars_i.b & vars_i.c) | (vars_i.b & vars_i.d) | (vars_i.c & vars_i.d);
      k = sha1md_pkg::K2;
    end else begin
      f = vars_i.b ^ vars_i.c ^ vars_i.d;
      k = sha1md_pkg::K3;
    end
    t = {vars_i.a[26:0], vars_i.a[31:27]} + f + vars_i.e + k + w_i;
  end

  assign vars_o.a = t;
  assign vars_o.b = vars_i.a;
  assign vars_o.c = {vars_i.b[1:0], vars_i.b[31:2]};
  assign vars_o.d = vars_i.c;
  assign vars_o.e = vars_i.d;

endmodule

// ===== sv/sha1md_sched.sv =====
`timescale 1ns / 1ps
// sha1md_sched: sixteen-word shift line holding the block and rolling schedule
// depends on sha1md_pkg

module sha1md_sched (
  input  logic                   clk,
  input  sha1md_pkg::sched_ctl_t ctl_i,
  input  sha1md_pkg::word_t      ext_word_i,
  output sha1md_pkg::word_t      cur_word_o
);

  sha1md_pkg::word_t w_r [16];
  sha1md_pkg::word_t x;
  sha1md_pkg::word_t shift_in;

  // taps: w_r[0] is w[i-16], w_r[2] w[i-14], w_r[8] w[i-8], w_r[13] w[i-3]
  assign x          = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign cur_word_o = ctl_i.expand ? {x[30:0], x[31]} : w_r[0];
  assign shift_in   = ctl_i.ext ? ext_word_i : cur_word_o;

  always_ff @(posedge clk) begin
    if (ctl_i.shift) begin
      for (int j = 0; j < 15; j++) begin
        w_r[j] <= w_r[j+1];
      end
      w_r[15] <= shift_in;
    end
  end

endmodule

// ===== sv/sha1_message_digest_unit.sv =====
`timescale 1ns / 1ps
// sha1_message_digest_unit: streaming sha-1 engine, top level and sequencer
// depends on sha1md_pkg, sha1md_round, sha1md_sched

// Byte-serial SHA-1. One message byte per input transaction; the byte is
// absorbed and the input is ready again in the next cycle, except on the
// 64th byte of a block, which starts the compression: the 80 rounds run in
// turn through the single shared round unit, then the working variables
// are folded into the chaining value with one adder, the input stalled
// throughout. A transaction with in_last_byte set adds the padding: the
// 0x80 word, zero words up to word 14 and a turnaround step, the two length
// words, and one or two more compressions (two when the 0x80 lands in
// word 14 or 15, with one more turnaround step before
// the first of them). The five digest words h0..h4
// then leave on the out_ channel, one per transaction, out_last_word marking
// h4; the input stays stalled until h4 is taken, and the engine then starts a
// fresh message. An item with neither a byte nor last is taken and ignored; an
// item with last and no byte finishes whatever was absorbed (the empty message
// if nothing was).

module sha1_message_digest_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic        out_last_word
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_FOLD,
    S_PAD80,
    S_ZERO,
    S_LENHI,
    S_LENLO,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_ABSORB,
    PH_PAD,
    PH_LEN
  } phase_t;

  localparam logic [4:0] WCNT_FULL = 5'd16;
  localparam logic [4:0] WCNT_LEN  = 5'd14;
  localparam logic [2:0] FOLD_LAST = 3'd4;
  localparam logic [2:0] OUT_LAST  = 3'd4;
  localparam logic [5:0] POS_LAST  = 6'd63;
  localparam logic [1:0] BYTE_LAST = 2'd3;

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic              last_r, last_nxt;
  logic [63:0]       bitcnt_r, bitcnt_nxt;
  logic [4:0]        wcnt_r, wcnt_nxt;
  logic [6:0]        ridx_r, ridx_nxt;
  logic [2:0]        fcnt_r, fcnt_nxt;
  logic [2:0]        ocnt_r, ocnt_nxt;
  sha1md_pkg::word_t h_r [5];
  sha1md_pkg::word_t h_nxt [5];
  sha1md_pkg::word_t acc_r, acc_nxt;
  sha1md_pkg::rvars_t v_r, v_nxt;

  sha1md_pkg::rvars_t     round_out;
  sha1md_pkg::word_t      cur_word;
  sha1md_pkg::word_t      ext_word;
  sha1md_pkg::sched_ctl_t sctl;

  logic [5:0]        pos;
  logic [4:0]        sh;
  sha1md_pkg::word_t base;
  sha1md_pkg::word_t in_word;
  sha1md_pkg::word_t pad_word;
  sha1md_pkg::rvars_t h_vars;

  // byte position in the block comes from the bit count
  assign pos      = bitcnt_r[8:3];
  // big-endian lane: byte 0 of a word sits in bits 31:24
  assign sh       = {~pos[1:0], 3'b000};
  assign base     = (pos[1:0] == 2'd0) ? '0 : acc_r;
  assign in_word  = base | (sha1md_pkg::word_t'(in_data_byte) << sh);
  assign pad_word = base | (sha1md_pkg::word_t'(sha1md_pkg::PAD_BYTE) << sh);
  assign h_vars   = '{a: h_r[0], b: h_r[1], c: h_r[2], d: h_r[3], e: h_r[4]};

  sha1md_round u_round (
    .vars_i (v_r),
    .w_i    (cur_word),
    .idx_i  (ridx_r),
    .vars_o (round_out)
  );

  sha1md_sched u_sched (
    .clk        (clk),
    .ctl_i      (sctl),
    .ext_word_i (ext_word),
    .cur_word_o (cur_word)
  );

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_digest_word = h_r[0];
  assign out_last_word   = (ocnt_r == OUT_LAST);

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    last_nxt   = last_r;
    bitcnt_nxt = bitcnt_r;
    wcnt_nxt   = wcnt_r;
    ridx_nxt   = ridx_r;
    fcnt_nxt   = fcnt_r;
    ocnt_nxt   = ocnt_r;
    h_nxt      = h_r;
    acc_nxt    = acc_r;
    v_nxt      = v_r;
    sctl       = '0;
    ext_word   = in_word;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          last_nxt = in_last_byte;
          if (in_has_byte) begin
            acc_nxt    = in_word;
            bitcnt_nxt = bitcnt_r + 64'd8;
            if (pos[1:0] == BYTE_LAST) begin
              sctl.shift = 1'b1;
              sctl.ext   = 1'b1;
            end
          end
          if (in_has_byte && pos == POS_LAST) begin
            // full block: compress before anything else
            v_nxt     = h_vars;
            ridx_nxt  = '0;
            state_nxt = S_ROUND;
          end else if (in_last_byte) begin
            state_nxt = S_PAD80;
          end
        end
      end

      S_ROUND: begin
        sctl.shift   = 1'b1;
        sctl.expand  = (ridx_r >= sha1md_pkg::ROUND_EXP);
        v_nxt        = round_out;
        ridx_nxt     = ridx_r + 7'd1;
        if (ridx_r == sha1md_pkg::ROUND_LAST) begin
          ridx_nxt  = '0;
          fcnt_nxt  = '0;
          state_nxt = S_FOLD;
        end
      end

      S_FOLD: begin
        // rotate chain and working variables together through one adder
        for (int j = 0; j < 4; j++) begin
          h_nxt[j] = h_r[j+1];
        end
        h_nxt[4] = h_r[0] + v_r.a;
        v_nxt    = '{a: v_r.b, b: v_r.c, c: v_r.d, d: v_r.e, e: v_r.a};
        fcnt_nxt = fcnt_r + 3'd1;
        if (fcnt_r == FOLD_LAST) begin
          case (phase_r)
            PH_ABSORB: state_nxt = last_r ? S_PAD80 : S_IDLE;
            PH_PAD: begin
              wcnt_nxt  = '0;
              state_nxt = S_ZERO;
            end
            PH_LEN: begin
              ocnt_nxt  = '0;
              state_nxt = S_OUT;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_PAD80: begin
        sctl.shift = 1'b1;
        sctl.ext   = 1'b1;
        ext_word   = pad_word;
        wcnt_nxt   = {1'b0, pos[5:2]} + 5'd1;
        phase_nxt  = PH_PAD;
        state_nxt  = S_ZERO;
      end

      S_ZERO: begin
        if (wcnt_r == WCNT_FULL) begin
          // no room for the length: compress and pad a second block
          v_nxt     = h_vars;
          ridx_nxt  = '0;
          state_nxt = S_ROUND;
        end else if (wcnt_r == WCNT_LEN) begin
          state_nxt = S_LENHI;
        end else begin
          sctl.shift = 1'b1;
          sctl.ext   = 1'b1;
          ext_word   = '0;
          wcnt_nxt   = wcnt_r + 5'd1;
        end
      end

      S_LENHI: begin
        sctl.shift = 1'b1;
        sctl.ext   = 1'b1;
        ext_word   = bitcnt_r[63:32];
        state_nxt  = S_LENLO;
      end

      S_LENLO: begin
        sctl.shift = 1'b1;
        sctl.ext   = 1'b1;
        ext_word   = bitcnt_r[31:0];
        phase_nxt  = PH_LEN;
        v_nxt      = h_vars;
        ridx_nxt   = '0;
        state_nxt  = S_ROUND;
      end

      S_OUT: begin
        if (!out_stall) begin
          for (int j = 0; j < 4; j++) begin
            h_nxt[j] = h_r[j+1];
          end
          h_nxt[4] = h_r[0];
          ocnt_nxt = ocnt_r + 3'd1;
          if (ocnt_r == OUT_LAST) begin
            // message done: back to the initial chaining value
            h_nxt[0]   = sha1md_pkg::IV0;
            h_nxt[1]   = sha1md_pkg::IV1;
            h_nxt[2]   = sha1md_pkg::IV2;
            h_nxt[3]   = sha1md_pkg::IV3;
            h_nxt[4]   = sha1md_pkg::IV4;
            bitcnt_nxt = '0;
            phase_nxt  = PH_ABSORB;
            last_nxt   = 1'b0;
            ocnt_nxt   = '0;
            state_nxt  = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      phase_r  <= PH_ABSORB;
      last_r   <= 1'b0;
      bitcnt_r <= '0;
      wcnt_r   <= '0;
      ridx_r   <= '0;
      fcnt_r   <= '0;
      ocnt_r   <= '0;
      h_r[0]   <= sha1md_pkg::IV0;
      h_r[1]   <= sha1md_pkg::IV1;
      h_r[2]   <= sha1md_pkg::IV2;
      h_r[3]   <= sha1md_pkg::IV3;
      h_r[4]   <= sha1md_pkg::IV4;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      last_r   <= last_nxt;
      bitcnt_r <= bitcnt_nxt;
      wcnt_r   <= wcnt_nxt;
      ridx_r   <= ridx_nxt;
      fcnt_r   <= fcnt_nxt;
      ocnt_r   <= ocnt_nxt;
      h_r      <= h_nxt;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    v_r   <= v_nxt;
  end

endmodule

// ===== sv/sha1md_checker.sv =====
`timescale 1ns / 1ps
// sha1md_checker: port-level assertions for the sha-1 digest unit
// depends on nothing; bound to sha1_message_digest_unit below

module sha1md_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_data_byte,
  input logic        in_has_byte,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_digest_word,
  input logic        out_last_word
);

  // a stalled digest word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_word)
                               && $stable(out_last_word))
    else $error("digest word changed while stalled");

  // no input taken while digest words are pending
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input ready during digest output");

  // a last transaction starts padding, not an immediate digest
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_byte |=> in_stall && !out_valid)
    else $error("engine not busy after last transaction");

  // the burst opens with h0
  a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !out_last_word)
    else $error("digest burst opened with last word");

  // the burst closes after h4
  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_word |=> !out_valid && !in_stall)
    else $error("digest burst did not end after last word");

endmodule

bind sha1_message_digest_unit sha1md_checker u_sha1md_checker (.*);

// ===== tb/sv/tb_sha1_message_digest_unit.sv =====
`timescale 1ns / 1ps
// tb_sha1_message_digest_unit: self-checking testbench of the streaming sha-1 unit
// depends on sha1md_pkg and sha1_message_digest_unit

module tb_sha1_message_digest_unit;

  localparam int unsigned STALL_PCT = 32;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_ITEMS = 180;
  localparam int unsigned DRAIN_CYCLES = 40;
  // worst quiet stretch: receiver hold-off plus padding and two compressions,
  // with margin for random gaps on both sides
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  // software copy of the engine: byte packing, padding, compression, and the
  // queue of digest words still to come out
  class digest_scoreboard;
    sha1md_pkg::word_t chain[5];
    sha1md_pkg::word_t blk[16];
    logic [63:0]       bit_count;
    sha1md_pkg::word_t digest_q[$];
    logic              last_word_q[$];
    int unsigned       errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = sha1md_pkg::IV0;
      chain[1] = sha1md_pkg::IV1;
      chain[2] = sha1md_pkg::IV2;
      chain[3] = sha1md_pkg::IV3;
      chain[4] = sha1md_pkg::IV4;
      foreach (blk[i]) blk[i] = '0;
      bit_count = '0;
    endfunction

    function sha1md_pkg::word_t rotl(sha1md_pkg::word_t x, int unsigned n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function void put_byte(int unsigned pos, logic [7:0] b);
      int unsigned widx;
      widx = (pos >> 2) & 15;
      if ((pos & 3) == 0) blk[widx] = '0;
      blk[widx] |= sha1md_pkg::word_t'(b) << (24 - 8 * (pos & 3));
    endfunction

    function void fold_block();
      sha1md_pkg::word_t w[16];
      sha1md_pkg::word_t a, b, c, d, e, f, k, t;
      int unsigned i;
      w = blk;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (i = 0; i < 80; i++) begin
        if (i >= 16)
          w[i & 15] = rotl(w[(i - 3) & 15] ^ w[(i - 8) & 15] ^ w[(i - 14) & 15] ^ w[i & 15], 1);
        if (i < 20) begin
          f = (b & c) | (~b & d);
          k = sha1md_pkg::K0;
        end else if (i < 40) begin
          f = b ^ c ^ d;
          k = sha1md_pkg::K1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = sha1md_pkg::K2;
        end else begin
          f = b ^ c ^ d;
          k = sha1md_pkg::K3;
        end
        t = rotl(a, 5) + f + e + k + w[i & 15];
        e = d;
        d = c;
        c = rotl(b, 30);
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    // one accepted input transaction
    function void absorb_item(logic [7:0] data, logic has, logic last);
      int unsigned pos;
      int j;
      if (has) begin
        pos = 32'(bit_count[8:3]);
        put_byte(pos, data);
        bit_count += 64'd8;
        if (pos == 63) fold_block();
      end
      if (!last) return;
      pos = 32'(bit_count[8:3]);
      put_byte(pos, sha1md_pkg::PAD_BYTE);
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin
          put_byte(pos, 8'h00);
          pos++;
        end
        fold_block();
        pos = 0;
      end
      while (pos < 56) begin
        put_byte(pos, 8'h00);
        pos++;
      end
      blk[14] = bit_count[63:32];
      blk[15] = bit_count[31:0];
      fold_block();
      for (j = 0; j < 5; j++) begin
        digest_q    = {digest_q, chain[j]};
        last_word_q = {last_word_q, (j == 4)};
      end
      restart();
    endfunction

    // one accepted result transaction
    function void check_result(sha1md_pkg::word_t word, logic last_word);
      sha1md_pkg::word_t exp_word;
      logic              exp_last;
      if (digest_q.size() == 0) begin
        $error("digest_word: no digest word expected, actual %08h", word);
        errors++;
        return;
      end
      exp_word = digest_q.pop_front();
      exp_last = last_word_q.pop_front();
      if (word !== exp_word) begin
        $error("digest_word mismatch: expected %08h actual %08h", exp_word, word);
        errors++;
      end
      if (last_word !== exp_last) begin
        $error("last_word mismatch: expected %0b actual %0b", exp_last, last_word);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return digest_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_has_byte = 1'b0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic        out_last_word;

  digest_scoreboard sb = new();

  // no random idling on either side while set
  bit          calm = 1'b0;
  // sender asks the receiver for one long hold-off
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent = 0;

  sha1_message_digest_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_has_byte    (in_has_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digest_word(out_digest_word),
    .out_last_word  (out_last_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, or one long hold-off counted here so the
  // engine backs up into its input while the sender keeps offering
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < STALL_PCT);
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_digest_word, out_last_word);
  end

  // watchdog: ends the run after too many cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one input transaction, with random gaps before it unless calm;
  // valid stays high straight into the next item when there is no gap
  task automatic send_item(logic [7:0] data, logic has, logic last);
    while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_has_byte  <= has;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    sb.absorb_item(data, has, last);
    if (has || last) items_sent++;
  endtask

  // a message of random bytes; idle items sprinkled in as noise; the end
  // comes either on the final byte or as a separate item with no byte
  task automatic send_message(int unsigned len, bit split_last, bit hold);
    int unsigned i;
    bit          end_on_byte;
    end_on_byte = (len != 0) && !split_last;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 8) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      if (end_on_byte && i == len - 1) begin
        if (hold) hold_req = 1'b1;
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      end else begin
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end
    end
    if (!end_on_byte) begin
      if (hold) hold_req = 1'b1;
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  // nothing more on offer: drop valid so the last item is not taken twice
  task automatic wait_digests_out();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned msg;
    int unsigned len;
    int unsigned pick;
    int unsigned base;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: idle item, empty message, "abc", byte with last,
    // and a message ended by a separate last item after an idle item
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'h3C, 1'b0, 1'b1);

    // sender pauses until every digest word has come out
    wait_digests_out();

    // random messages: first a length that needs two padding blocks, then
    // the longest one-block padding, then mostly short messages
    msg = 0;
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      calm = (msg >= 3 && msg <= 5);
      pick = $urandom_range(0, 99);
      if (msg == 0) len = $urandom_range(56, 63);
      else if (msg == 1) len = 55;
      else if (pick < 70) len = $urandom_range(0, 12);
      else if (pick < 85) len = $urandom_range(52, 66);
      else len = $urandom_range(13, 51);
      send_message(len, $urandom_range(0, 3) == 0, msg == 2);
      msg++;
    end
    calm = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    wait_digests_out();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
